>>> design/ecr_pkg.sv
// ecr_pkg: widths, status codes, stage payload types and the output clamp
// shared by the elastic collision response datapath
// no dependencies
package ecr_pkg;

    localparam int VW    = 32;          // velocity / position width
    localparam int DRW   = 33;          // position and velocity differences
    localparam int MW    = 33;          // mass sum and doubled masses
    localparam int DOTW  = 66;          // |<dv,dr>| and |dr|^2
    localparam int TW    = DOTW + DRW;  // |dot| * |d|
    localparam int NUMW  = MW + TW;     // 2m * |dot| * |d|
    localparam int DENW  = MW + DOTW;   // (ma+mb) * |dr|^2
    localparam int QW    = 35;          // quotient bound: |delta| < 2^34
    localparam int SW    = QW + 2;      // signed update width

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COINC = 2'd1;
    localparam logic [1:0] ST_ZMASS = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic signed [VW-1:0] vax;
        logic signed [VW-1:0] vay;
        logic signed [VW-1:0] vbx;
        logic signed [VW-1:0] vby;
        logic                 coinc;
        logic                 zmass;
    } t_side;

    typedef struct packed {
        logic [DOTW-1:0] dot_mag;
        logic [DOTW-1:0] nrm;
        logic [DRW-1:0]  dmag_x;
        logic [DRW-1:0]  dmag_y;
        logic            sgn_x;
        logic            sgn_y;
        logic [MW-1:0]   msum;
        logic [MW-1:0]   ma2;
        logic [MW-1:0]   mb2;
        t_side           side;
    } t_front;

    typedef struct packed {
        logic  sgn_x;
        logic  sgn_y;
        t_side side;
    } t_mid;

    // clamp to 32 bits, top bit reports clamping
    function automatic logic [VW:0] sat32(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] smax;
        logic signed [SW-1:0] smin;
        logic [VW:0]          res;
        smax = SW'(32'sh7fffffff);
        smin = SW'(-33'sh80000000);
        if (x > smax) begin
            res = {1'b1, 32'h7fffffff};
        end else if (x < smin) begin
            res = {1'b1, 32'h80000000};
        end else begin
            res = {1'b0, x[VW-1:0]};
        end
        return res;
    endfunction

endpackage

>>> design/ecr_mul.sv
// ecr_mul: two-stage unsigned multiplier, b cut into 32-bit partial products
// depends on nothing
module ecr_mul #(
    parameter int AW = 33,
    parameter int BW = 66
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);
    localparam int CW = 32;
    localparam int NC = (BW + CW - 1) / CW;

    logic [NC*CW-1:0] w_bpad;
    logic [AW+CW-1:0] r_pp [NC];
    logic [NC*CW+AW-1:0] w_acc;
    logic [AW+BW-1:0] r_p;

    assign w_bpad = (NC*CW)'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NC; c++) begin
                r_pp[c] <= (AW+CW)'(i_a) * (AW+CW)'(w_bpad[c*CW +: CW]);
            end
            r_p <= w_acc[AW+BW-1:0];
        end
    end

    always_comb begin
        w_acc = '0;
        for (int c = 0; c < NC; c++) begin
            w_acc = w_acc + ((NC*CW+AW)'(r_pp[c]) << (c*CW));
        end
    end

    assign o_p = r_p;

endmodule

>>> design/ecr_div.sv
// ecr_div: pipelined restoring divider, one quotient bit per stage
// quotient must be below 2^QW; depends on nothing
module ecr_div #(
    parameter int NW = 132,
    parameter int DW = 99,
    parameter int QW = 35
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_q
);
    localparam int WW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_q   [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [NW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_q_in;
        logic [WW-1:0] w_trial;
        logic          w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_q_in   = r_q[s-1];
        end

        assign w_trial = WW'(w_den_in) << (QW - 1 - s);
        assign w_ge    = WW'(w_rem_in) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s] <= w_q_in | (QW'(w_ge) << (QW - 1 - s));
            end
        end

        if (s < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_ge ? w_rem_in - w_trial[NW-1:0] : w_rem_in;
                    r_den[s] <= w_den_in;
                end
            end
        end
    end

    assign o_q = r_q[QW-1];

endmodule

>>> design/ecr_front.sv
// ecr_front: first three pipeline stages: differences, products, dot and norm
// depends on ecr_pkg
module ecr_front
    import ecr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [31:0]          i_mass_a,
    input  logic [31:0]          i_mass_b,
    input  logic signed [31:0]   i_pos_ax,
    input  logic signed [31:0]   i_pos_ay,
    input  logic signed [31:0]   i_pos_bx,
    input  logic signed [31:0]   i_pos_by,
    input  logic signed [31:0]   i_vel_ax,
    input  logic signed [31:0]   i_vel_ay,
    input  logic signed [31:0]   i_vel_bx,
    input  logic signed [31:0]   i_vel_by,
    output logic                 o_valid,
    output t_front               o_front
);
    logic [2:0] r_vld;

    logic signed [DRW-1:0] r1_drx, r1_dry, r1_dvx, r1_dvy;
    logic [MW-1:0]         r1_msum, r1_ma2, r1_mb2;
    t_side                 r1_side;

    logic signed [DOTW-1:0] r2_pxx, r2_pyy, r2_nxx, r2_nyy;
    logic signed [DRW-1:0]  r2_drx, r2_dry;
    logic [MW-1:0]          r2_msum, r2_ma2, r2_mb2;
    t_side                  r2_side;

    logic signed [DOTW:0]   w_dot;
    logic signed [DOTW:0]   w_dot_abs;
    logic signed [DRW-1:0]  w_adx, w_ady;
    t_front                 r3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_drx  <= DRW'(i_pos_ax) - DRW'(i_pos_bx);
            r1_dry  <= DRW'(i_pos_ay) - DRW'(i_pos_by);
            r1_dvx  <= DRW'(i_vel_ax) - DRW'(i_vel_bx);
            r1_dvy  <= DRW'(i_vel_ay) - DRW'(i_vel_by);
            r1_msum <= {1'b0, i_mass_a} + {1'b0, i_mass_b};
            r1_ma2  <= {i_mass_a, 1'b0};
            r1_mb2  <= {i_mass_b, 1'b0};
            r1_side.vax   <= i_vel_ax;
            r1_side.vay   <= i_vel_ay;
            r1_side.vbx   <= i_vel_bx;
            r1_side.vby   <= i_vel_by;
            r1_side.coinc <= (i_pos_ax == i_pos_bx) && (i_pos_ay == i_pos_by);
            r1_side.zmass <= (i_mass_a == '0) && (i_mass_b == '0);

            r2_pxx  <= DOTW'(r1_dvx) * DOTW'(r1_drx);
            r2_pyy  <= DOTW'(r1_dvy) * DOTW'(r1_dry);
            r2_nxx  <= DOTW'(r1_drx) * DOTW'(r1_drx);
            r2_nyy  <= DOTW'(r1_dry) * DOTW'(r1_dry);
            r2_drx  <= r1_drx;
            r2_dry  <= r1_dry;
            r2_msum <= r1_msum;
            r2_ma2  <= r1_ma2;
            r2_mb2  <= r1_mb2;
            r2_side <= r1_side;

            r3.dot_mag <= w_dot_abs[DOTW-1:0];
            r3.nrm     <= $unsigned(r2_nxx) + $unsigned(r2_nyy);
            r3.dmag_x  <= $unsigned(w_adx);
            r3.dmag_y  <= $unsigned(w_ady);
            r3.sgn_x   <= w_dot[DOTW] ^ r2_drx[DRW-1];
            r3.sgn_y   <= w_dot[DOTW] ^ r2_dry[DRW-1];
            r3.msum    <= r2_msum;
            r3.ma2     <= r2_ma2;
            r3.mb2     <= r2_mb2;
            r3.side    <= r2_side;
        end
    end

    always_comb begin
        w_dot     = (DOTW+1)'(r2_pxx) + (DOTW+1)'(r2_pyy);
        w_dot_abs = w_dot[DOTW] ? -w_dot : w_dot;
        // magnitude of -2^32 wraps to the right unsigned value
        w_adx     = r2_drx[DRW-1] ? -r2_drx : r2_drx;
        w_ady     = r2_dry[DRW-1] ? -r2_dry : r2_dry;
    end

    assign o_valid = r_vld[2];
    assign o_front = r3;

endmodule

>>> design/disc_elastic_collision_response_top.sv
// disc_elastic_collision_response_top: 2d elastic collision velocity update
// depends on ecr_pkg, ecr_front, ecr_mul, ecr_div
//
// usage:
//   input channel i_valid / o_ready carries masses, centres and velocities
//   of one disc pair; output channel o_valid / i_ready carries the four new
//   velocities and a status code (ok, coincident centres, zero total mass,
//   saturated). one transfer in gives exactly one transfer out, in order.
//   the pipe is 3 front stages, then split multipliers for the numerators
//   and the denominator, 35 restoring divider stages (one quotient bit each)
//   and the output register. throughput is one pair per cycle unless the
//   receiver stalls; the whole pipe advances on one enable, so o_ready is
//   high whenever the output register is empty or taken.
//   when the receiver stalls, every stage holds its contents and o_ready
//   drops in the same cycle; nothing is dropped or repeated.
//   reset (synchronous, active low) clears all valid bits; data registers
//   are not reset. there is no configuration.
module disc_elastic_collision_response_top
    import ecr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_mass_a,
    input  logic [31:0]        i_mass_b,
    input  logic signed [31:0] i_pos_ax,
    input  logic signed [31:0] i_pos_ay,
    input  logic signed [31:0] i_pos_bx,
    input  logic signed [31:0] i_pos_by,
    input  logic signed [31:0] i_vel_ax,
    input  logic signed [31:0] i_vel_ay,
    input  logic signed [31:0] i_vel_bx,
    input  logic signed [31:0] i_vel_by,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_new_vel_ax,
    output logic signed [31:0] o_new_vel_ay,
    output logic signed [31:0] o_new_vel_bx,
    output logic signed [31:0] o_new_vel_by,
    output logic [1:0]         o_status
);
    localparam int LB = 4 + QW;

    logic            w_en;
    logic            w_front_vld;
    t_front          w_front;

    logic [LB-1:0]   r_vld;
    t_mid            r_mid [LB];
    logic [MW-1:0]   r_ma2 [2];
    logic [MW-1:0]   r_mb2 [2];
    logic [DENW-1:0] r_den [2];

    logic [TW-1:0]   w_tx, w_ty;
    logic [DENW-1:0] w_den;
    logic [NUMW-1:0] w_nax, w_nay, w_nbx, w_nby;
    logic [QW-1:0]   w_qax, w_qay, w_qbx, w_qby;

    t_mid                 w_fin;
    logic                 w_fin_vld;
    logic signed [SW-1:0] w_dx, w_dy;
    logic [VW:0]          w_sax, w_say, w_sbx, w_sby;
    logic [1:0]           w_status;

    logic                 r_out_vld;
    logic signed [31:0]   r_ax, r_ay, r_bx, r_by;
    logic [1:0]           r_status;

    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;

    ecr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_mass_a (i_mass_a),
        .i_mass_b (i_mass_b),
        .i_pos_ax (i_pos_ax),
        .i_pos_ay (i_pos_ay),
        .i_pos_bx (i_pos_bx),
        .i_pos_by (i_pos_by),
        .i_vel_ax (i_vel_ax),
        .i_vel_ay (i_vel_ay),
        .i_vel_bx (i_vel_bx),
        .i_vel_by (i_vel_by),
        .o_valid  (w_front_vld),
        .o_front  (w_front)
    );

    // |dot| * |d| per axis and (ma+mb) * |dr|^2
    ecr_mul #(.AW(DRW), .BW(DOTW)) u_mul_tx (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_front.dmag_x), .i_b(w_front.dot_mag), .o_p(w_tx)
    );
    ecr_mul #(.AW(DRW), .BW(DOTW)) u_mul_ty (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_front.dmag_y), .i_b(w_front.dot_mag), .o_p(w_ty)
    );
    ecr_mul #(.AW(MW), .BW(DOTW)) u_mul_den (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_front.msum), .i_b(w_front.nrm), .o_p(w_den)
    );

    // numerators: disc a uses 2*mb, disc b uses 2*ma
    ecr_mul #(.AW(MW), .BW(TW)) u_mul_nax (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_mb2[1]), .i_b(w_tx), .o_p(w_nax)
    );
    ecr_mul #(.AW(MW), .BW(TW)) u_mul_nay (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_mb2[1]), .i_b(w_ty), .o_p(w_nay)
    );
    ecr_mul #(.AW(MW), .BW(TW)) u_mul_nbx (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_ma2[1]), .i_b(w_tx), .o_p(w_nbx)
    );
    ecr_mul #(.AW(MW), .BW(TW)) u_mul_nby (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_ma2[1]), .i_b(w_ty), .o_p(w_nby)
    );

    ecr_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div_ax (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_nax), .i_den(r_den[1]), .o_q(w_qax)
    );
    ecr_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div_ay (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_nay), .i_den(r_den[1]), .o_q(w_qay)
    );
    ecr_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div_bx (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_nbx), .i_den(r_den[1]), .o_q(w_qbx)
    );
    ecr_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div_by (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_nby), .i_den(r_den[1]), .o_q(w_qby)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[LB-2:0], w_front_vld};
            r_out_vld <= w_fin_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mid[0] <= '{sgn_x: w_front.sgn_x, sgn_y: w_front.sgn_y, side: w_front.side};
            for (int i = 1; i < LB; i++) begin
                r_mid[i] <= r_mid[i-1];
            end
            r_ma2[0] <= w_front.ma2;
            r_ma2[1] <= r_ma2[0];
            r_mb2[0] <= w_front.mb2;
            r_mb2[1] <= r_mb2[0];
            r_den[0] <= w_den;
            r_den[1] <= r_den[0];
        end
    end

    assign w_fin     = r_mid[LB-1];
    assign w_fin_vld = r_vld[LB-1];

    always_comb begin
        w_dx  = w_fin.sgn_x ? -$signed({2'b00, w_qax}) : $signed({2'b00, w_qax});
        w_dy  = w_fin.sgn_y ? -$signed({2'b00, w_qay}) : $signed({2'b00, w_qay});
        w_sax = sat32(SW'(w_fin.side.vax) - w_dx);
        w_say = sat32(SW'(w_fin.side.vay) - w_dy);
        // disc b shares the sign, only the magnitude differs
        w_sbx = sat32(SW'(w_fin.side.vbx)
                      + (w_fin.sgn_x ? -$signed({2'b00, w_qbx}) : $signed({2'b00, w_qbx})));
        w_sby = sat32(SW'(w_fin.side.vby)
                      + (w_fin.sgn_y ? -$signed({2'b00, w_qby}) : $signed({2'b00, w_qby})));
        if (w_fin.side.coinc) begin
            w_status = ST_COINC;
        end else if (w_fin.side.zmass) begin
            w_status = ST_ZMASS;
        end else if (w_sax[VW] || w_say[VW] || w_sbx[VW] || w_sby[VW]) begin
            w_status = ST_SAT;
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_status <= w_status;
            if (w_fin.side.coinc || w_fin.side.zmass) begin
                r_ax <= w_fin.side.vax;
                r_ay <= w_fin.side.vay;
                r_bx <= w_fin.side.vbx;
                r_by <= w_fin.side.vby;
            end else begin
                r_ax <= $signed(w_sax[VW-1:0]);
                r_ay <= $signed(w_say[VW-1:0]);
                r_bx <= $signed(w_sbx[VW-1:0]);
                r_by <= $signed(w_sby[VW-1:0]);
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_new_vel_ax = r_ax;
    assign o_new_vel_ay = r_ay;
    assign o_new_vel_bx = r_bx;
    assign o_new_vel_by = r_by;
    assign o_status     = r_status;

    a_coinc_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_fin_vld && w_fin.side.coinc) |=> (o_valid && o_status == ST_COINC))
        else $error("coincident item lost its status");

    a_zmass_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_fin_vld && !w_fin.side.coinc && w_fin.side.zmass)
        |=> (o_valid && o_status == ST_ZMASS))
        else $error("zero mass item lost its status");

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_fin_vld && w_fin.side.coinc)
        |=> (o_new_vel_ax == $past(w_fin.side.vax) && o_new_vel_by == $past(w_fin.side.vby)))
        else $error("coincident item velocities changed");

endmodule

>>> bench/collision_checker.sv
// collision_checker: watches both channels of the collision response block,
// predicts each new velocity set and compares it field by field
// depends on ecr_pkg for the status codes
module collision_checker
    import ecr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [31:0]        i_mass_a,
    input  logic [31:0]        i_mass_b,
    input  logic signed [31:0] i_pos_ax,
    input  logic signed [31:0] i_pos_ay,
    input  logic signed [31:0] i_pos_bx,
    input  logic signed [31:0] i_pos_by,
    input  logic signed [31:0] i_vel_ax,
    input  logic signed [31:0] i_vel_ay,
    input  logic signed [31:0] i_vel_bx,
    input  logic signed [31:0] i_vel_by,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [31:0] o_new_vel_ax,
    input  logic signed [31:0] o_new_vel_ay,
    input  logic signed [31:0] o_new_vel_bx,
    input  logic signed [31:0] o_new_vel_by,
    input  logic [1:0]         o_status,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] vax;
        logic [31:0] vay;
        logic [31:0] vbx;
        logic [31:0] vby;
        logic [1:0]  status;
    } t_velocity_set;

    localparam logic [191:0] QUOT_MAX = 192'h3fff_ffff_ffff_ffff;

    t_velocity_set expected_velocities[$];

    // one exact velocity change, truncated toward zero
    function automatic longint velocity_change(logic [191:0] twice_m, logic [191:0] dot_mag,
                                               bit dot_neg, longint d, logic [191:0] den);
        logic [191:0] num;
        logic [191:0] d_abs;
        logic [191:0] q;
        longint       ql;
        d_abs = (d < 0) ? 192'(-d) : 192'(d);
        num = twice_m * dot_mag * d_abs;
        q = num / den;
        if (q > QUOT_MAX) q = QUOT_MAX;
        ql = longint'(q[63:0]);
        return (dot_neg != (d < 0)) ? -ql : ql;
    endfunction

    function automatic logic [31:0] clamp32(longint x, inout bit clamped);
        if (x > 64'sd2147483647) begin
            clamped = 1'b1;
            return 32'h7fffffff;
        end
        if (x < -64'sd2147483648) begin
            clamped = 1'b1;
            return 32'h80000000;
        end
        return x[31:0];
    endfunction

    function automatic t_velocity_set predict_collision();
        t_velocity_set      r;
        longint             drx, dry, vax, vay, vbx, vby;
        logic signed [127:0] wdrx, wdry, wdvx, wdvy, dot;
        logic [191:0]       dot_mag, nrm, msum, den, ma2, mb2;
        bit                 dot_neg;
        bit                 clamped;
        vax = i_vel_ax;
        vay = i_vel_ay;
        vbx = i_vel_bx;
        vby = i_vel_by;
        drx = longint'(i_pos_ax) - longint'(i_pos_bx);
        dry = longint'(i_pos_ay) - longint'(i_pos_by);
        r.vax = i_vel_ax;
        r.vay = i_vel_ay;
        r.vbx = i_vel_bx;
        r.vby = i_vel_by;
        r.status = ST_OK;
        if (drx == 0 && dry == 0) begin
            r.status = ST_COINC;
            return r;
        end
        if (i_mass_a == 0 && i_mass_b == 0) begin
            r.status = ST_ZMASS;
            return r;
        end
        wdrx = drx;
        wdry = dry;
        wdvx = vax - vbx;
        wdvy = vay - vby;
        dot = wdvx * wdrx + wdvy * wdry;
        dot_neg = dot < 0;
        dot_mag = dot_neg ? 192'(-dot) : 192'(dot);
        nrm = 192'(wdrx * wdrx + wdry * wdry);
        msum = 192'(i_mass_a) + 192'(i_mass_b);
        ma2 = 192'(i_mass_a) << 1;
        mb2 = 192'(i_mass_b) << 1;
        den = msum * nrm;
        clamped = 1'b0;
        r.vax = clamp32(vax - velocity_change(mb2, dot_mag, dot_neg, drx, den), clamped);
        r.vay = clamp32(vay - velocity_change(mb2, dot_mag, dot_neg, dry, den), clamped);
        r.vbx = clamp32(vbx + velocity_change(ma2, dot_mag, dot_neg, drx, den), clamped);
        r.vby = clamp32(vby + velocity_change(ma2, dot_mag, dot_neg, dry, den), clamped);
        r.status = clamped ? ST_SAT : ST_OK;
        return r;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_velocity_set e;
        if (i_rst_n && i_valid && o_ready) expected_velocities.push_back(predict_collision());
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_velocities.size() == 0) begin
                $display("%0t: result transfer with nothing expected", $time);
                o_errors <= o_errors + 1;
            end else begin
                e = expected_velocities.pop_front();
                if (o_new_vel_ax !== e.vax || o_new_vel_ay !== e.vay ||
                    o_new_vel_bx !== e.vbx || o_new_vel_by !== e.vby ||
                    o_status !== e.status) begin
                    $display("%0t: mismatch expected ax=%h ay=%h bx=%h by=%h st=%0d",
                             $time, e.vax, e.vay, e.vbx, e.vby, e.status);
                    $display("%0t:          actual   ax=%h ay=%h bx=%h by=%h st=%0d",
                             $time, o_new_vel_ax, o_new_vel_ay, o_new_vel_bx,
                             o_new_vel_by, o_status);
                    o_errors <= o_errors + 1;
                end
            end
        end
        o_pending <= expected_velocities.size();
    end

endmodule

>>> bench/testbench.sv
// testbench: drives disc pairs into the collision response block under
// several idle and stall patterns and gives the verdict
// depends on ecr_pkg, disc_elastic_collision_response_top, collision_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PAIRS = 1230;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [31:0]        i_mass_a = '0;
    logic [31:0]        i_mass_b = '0;
    logic signed [31:0] i_pos_ax = '0;
    logic signed [31:0] i_pos_ay = '0;
    logic signed [31:0] i_pos_bx = '0;
    logic signed [31:0] i_pos_by = '0;
    logic signed [31:0] i_vel_ax = '0;
    logic signed [31:0] i_vel_ay = '0;
    logic signed [31:0] i_vel_bx = '0;
    logic signed [31:0] i_vel_by = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_new_vel_ax;
    logic signed [31:0] o_new_vel_ay;
    logic signed [31:0] o_new_vel_bx;
    logic signed [31:0] o_new_vel_by;
    logic [1:0]         o_status;
    int                 errors;
    int                 pending;
    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;
    int                 quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    disc_elastic_collision_response_top dut (.*);

    collision_checker checker_i (.*, .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) i_ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(negedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // called at a rising edge, returns at the edge of the transfer
    task automatic send_pair(logic [31:0] ma, logic [31:0] mb, logic [31:0] pax,
                             logic [31:0] pay, logic [31:0] pbx, logic [31:0] pby,
                             logic [31:0] vax, logic [31:0] vay, logic [31:0] vbx,
                             logic [31:0] vby);
        bit taken;
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mass_a <= ma;
        i_mass_b <= mb;
        i_pos_ax <= pax;
        i_pos_ay <= pay;
        i_pos_bx <= pbx;
        i_pos_by <= pby;
        i_vel_ax <= vax;
        i_vel_ay <= vay;
        i_vel_bx <= vbx;
        i_vel_by <= vby;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    function automatic logic [31:0] pick_value(bit full);
        if (full) return $urandom;
        return $urandom_range(32'h0002_0000) - 32'h0001_0000;
    endfunction

    task automatic send_random_pair();
        logic [31:0] ma, mb, pax, pay, pbx, pby;
        int          kind;
        kind = $urandom_range(19);
        ma = ($urandom_range(1)) ? $urandom : $urandom_range(32'h0004_0000);
        mb = ($urandom_range(1)) ? $urandom : $urandom_range(32'h0004_0000);
        if (kind == 0) ma = 0;
        if (kind == 1) mb = 0;
        if (kind == 2) begin
            ma = 0;
            mb = 0;
        end
        pax = pick_value($urandom_range(1));
        pay = pick_value($urandom_range(1));
        // near neighbours mostly, far apart now and then
        pbx = ($urandom_range(3) == 0) ? $urandom : pax + pick_value(0);
        pby = ($urandom_range(3) == 0) ? $urandom : pay + pick_value(0);
        if (kind == 3) begin
            pbx = pax;
            pby = pay;
        end
        send_pair(ma, mb, pax, pay, pbx, pby, pick_value($urandom_range(2) == 0),
                  pick_value($urandom_range(2) == 0), pick_value($urandom_range(2) == 0),
                  pick_value($urandom_range(2) == 0));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // coincident centres, also with zero mass
        send_pair(32'h10000, 32'h10000, 32'h5, 32'h7, 32'h5, 32'h7, 1, 2, 3, 4);
        send_pair(0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000, 32'hffffffff, 0);
        // zero total mass
        send_pair(0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0, 0);
        // head on, equal masses: velocities swap
        send_pair(32'h10000, 32'h10000, 0, 0, 32'h20000, 0, 32'h10000, 0, 32'hffff0000, 0);
        // one disc massless, other massive
        send_pair(0, 32'hffffffff, 0, 0, 32'h10000, 32'h10000, 32'h30000, 32'h10000, 0, 0);
        send_pair(32'hffffffff, 0, 0, 0, 32'h10000, 32'h10000, 32'h30000, 32'h10000, 0, 0);
        // moving perpendicular to the centre line: zero dot product
        send_pair(32'h10000, 32'h20000, 0, 0, 32'h10000, 0, 0, 32'h50000, 0, 32'hfffb0000);
        // extreme positions and velocities, saturation
        send_pair(32'h1, 32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                  32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
        send_pair(32'hffffffff, 32'hffffffff, 32'h80000000, 0, 32'h7fffffff, 0,
                  32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_pair(32'hffffffff, 32'h1, 0, 32'h80000000, 0, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        send_pair(32'h1, 32'h1, 0, 0, 32'h1, 32'h1, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 32'h80000000);
        send_pair(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'hffffffff, 1, 1,
                  32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555);
        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct = (phase == 1) ? 71 : (phase == 3) ? 25 : 0;
            receiver_stall_pct = (phase == 2) ? 71 : (phase == 3) ? 25 : 0;
            for (int n = 0; n < RANDOM_PAIRS / 4; n++) send_random_pair();
        end
        i_valid <= 1'b0;
        receiver_stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
